### rtl/nawb_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the narrow access word bridge.
// No dependencies; imported by every module of the block.
package nawb_pkg;

  // Access kinds carried in req_type
  typedef enum logic [2:0] {
    REQ_RD_BYTE = 3'd0,
    REQ_RD_HALF = 3'd1,
    REQ_RD_WORD = 3'd2,
    REQ_WR_BYTE = 3'd3,
    REQ_WR_HALF = 3'd4,
    REQ_WR_WORD = 3'd5
  } req_kind_t;

  // Result kinds
  localparam logic RES_READ  = 1'b0;
  localparam logic RES_WRITE = 1'b1;

  // Configuration register indexes
  localparam logic CFG_SEED_BLOCK   = 1'b0;
  localparam logic CFG_SEED_COMMAND = 1'b1;

  // Register offsets with shadow handling
  localparam logic [7:0] OFF_BLOCK_SIZE  = 8'h04;
  localparam logic [7:0] OFF_BLOCK_COUNT = 8'h06;
  localparam logic [7:0] OFF_XFER_MODE   = 8'h0C;
  localparam logic [7:0] OFF_COMMAND     = 8'h0E;

  localparam logic [31:0] BYTE_MASK = 32'h0000_00FF;
  localparam logic [31:0] HALF_MASK = 32'h0000_FFFF;

  // Job queue depth
  localparam int unsigned QDEPTH = 2;

  // One queued job: an optional block word flush, then the main result
  typedef struct packed {
    logic        has_pre;
    logic [31:0] pre_data;
    logic        kind;
    logic [7:0]  woff;
    logic [31:0] data;
  } job_t;

endpackage

### rtl/nawb_req_if.sv
`timescale 1ns / 1ps
// Request channel: one access item with valid/ready handshake.
// No dependencies.
interface nawb_req_if;
  logic        valid;
  logic        ready;
  logic [2:0]  req_type;
  logic [7:0]  offset;
  logic [31:0] write_value;
  logic [31:0] fetched_word;

  modport source (output valid, req_type, offset, write_value, fetched_word, input ready);
  modport sink   (input valid, req_type, offset, write_value, fetched_word, output ready);
endinterface

### rtl/nawb_rsp_if.sv
`timescale 1ns / 1ps
// Result channel: one result item with valid/ready handshake.
// No dependencies.
interface nawb_rsp_if;
  logic        valid;
  logic        ready;
  logic        result_kind;
  logic [7:0]  word_offset;
  logic [31:0] result_data;
  logic        last;

  modport source (output valid, result_kind, word_offset, result_data, last, input ready);
  modport sink   (input valid, result_kind, word_offset, result_data, last, output ready);
endinterface

### rtl/nawb_front.sv
`timescale 1ns / 1ps
// Front end: accepts access items, classifies them, keeps the shadow words
// and pushes jobs into the queue. Uses nawb_pkg and nawb_req_if.
module nawb_front #(
  parameter int unsigned REG_SPACE_BYTES = 256
) (
  input  logic               clk,
  input  logic               rst,
  nawb_req_if.sink           req,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [31:0]        cfg_data,
  input  logic               room,
  output logic               push,
  output nawb_pkg::job_t     push_job
);
  import nawb_pkg::*;

  // offset mod REG_SPACE_BYTES by reciprocal; exact for 8-bit offsets
  localparam int unsigned RECIP = (65536 + REG_SPACE_BYTES - 1) / REG_SPACE_BYTES;

  logic [31:0] block_shadow;
  logic [31:0] command_shadow;
  logic        block_pending;

  logic [31:0] block_shadow_next;
  logic [31:0] command_shadow_next;
  logic        block_pending_next;

  logic [23:0] quot_prod;
  logic [23:0] back_prod;
  logic [7:0]  off;
  logic [7:0]  aligned;
  logic [4:0]  shift;
  logic        blk;
  logic        accept;
  logic [31:0] base;
  logic [31:0] merged;

  function automatic logic [31:0] merge_lane(input logic [31:0] word,
                                             input logic [31:0] val,
                                             input logic [31:0] mask,
                                             input logic [4:0]  sh);
    return (word & ~(mask << sh)) | ((val & mask) << sh);
  endfunction

  assign quot_prod = 24'(req.offset) * 24'(RECIP);
  assign back_prod = {16'd0, quot_prod[23:16]} * 24'(REG_SPACE_BYTES);
  assign off       = req.offset - back_prod[7:0];
  assign aligned   = {off[7:2], 2'b00};
  assign shift     = {off[1:0], 3'b000};
  assign blk       = (off == OFF_BLOCK_SIZE) || (off == OFF_BLOCK_COUNT);

  assign req.ready = room;
  assign accept    = req.valid && room;

  always_comb begin
    block_shadow_next   = block_shadow;
    command_shadow_next = command_shadow;
    block_pending_next  = block_pending;
    push                = 1'b0;
    push_job            = '0;
    base                = req.fetched_word;
    merged              = '0;
    case (req_kind_t'(req.req_type))
      REQ_RD_BYTE: begin
        push          = 1'b1;
        push_job.kind = RES_READ;
        push_job.data = (req.fetched_word >> shift) & BYTE_MASK;
      end
      REQ_RD_HALF: begin
        if (blk && block_pending) begin
          base = block_shadow;
        end else if ((off == OFF_XFER_MODE) || (off == OFF_COMMAND)) begin
          base = command_shadow;
        end
        push          = 1'b1;
        push_job.kind = RES_READ;
        push_job.data = (base >> shift) & HALF_MASK;
      end
      REQ_RD_WORD: begin
        push          = 1'b1;
        push_job.kind = RES_READ;
        push_job.data = req.fetched_word;
      end
      REQ_WR_BYTE: begin
        push          = 1'b1;
        push_job.kind = RES_WRITE;
        push_job.woff = aligned;
        push_job.data = merge_lane(req.fetched_word, req.write_value, BYTE_MASK, shift);
      end
      REQ_WR_HALF: begin
        if (blk && block_pending) begin
          base = block_shadow;
        end else if (off == OFF_COMMAND) begin
          base = command_shadow;
        end
        merged = merge_lane(base, req.write_value, HALF_MASK, shift);
        if (off == OFF_XFER_MODE) begin
          command_shadow_next = merged;
        end else if (blk) begin
          block_shadow_next  = merged;
          block_pending_next = 1'b1;
        end else begin
          if (off == OFF_COMMAND) begin
            // flush a held block word ahead of the command write
            push_job.has_pre    = block_pending;
            push_job.pre_data   = block_shadow;
            block_pending_next  = 1'b0;
            command_shadow_next = merged;
          end
          push          = 1'b1;
          push_job.kind = RES_WRITE;
          push_job.woff = aligned;
          push_job.data = merged;
        end
      end
      REQ_WR_WORD: begin
        push          = 1'b1;
        push_job.kind = RES_WRITE;
        push_job.woff = aligned;
        push_job.data = req.write_value;
      end
      default: begin
        // unused kinds: dropped
      end
    endcase
    if (!accept) begin
      push = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      block_shadow   <= '0;
      command_shadow <= '0;
      block_pending  <= 1'b0;
    end else if (accept) begin
      block_shadow   <= block_shadow_next;
      command_shadow <= command_shadow_next;
      block_pending  <= block_pending_next;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SEED_BLOCK:   block_shadow   <= cfg_data;
        CFG_SEED_COMMAND: command_shadow <= cfg_data;
        default: begin
        end
      endcase
    end
  end

endmodule

### rtl/nawb_queue.sv
`timescale 1ns / 1ps
// Short job queue between front and back end.
// Uses nawb_pkg (job_t, QDEPTH).
module nawb_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  nawb_pkg::job_t push_job,
  output logic           room,
  input  logic           pop,
  output logic           avail,
  output nawb_pkg::job_t head_job
);
  import nawb_pkg::*;

  localparam int unsigned PTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(QDEPTH + 1);

  job_t             entries [QDEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign room     = (count != CNT_W'(QDEPTH));
  assign avail    = (count != '0);
  assign head_job = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QDEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QDEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

### rtl/nawb_back.sv
`timescale 1ns / 1ps
// Back end: turns queued jobs into result items through an output register.
// Uses nawb_pkg and nawb_rsp_if.
module nawb_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           avail,
  input  nawb_pkg::job_t head_job,
  output logic           pop,
  nawb_rsp_if.source     rsp
);
  import nawb_pkg::*;

  logic        out_valid;
  logic        out_kind;
  logic [7:0]  out_woff;
  logic [31:0] out_data;
  logic        out_last;
  logic        phase;      // set once the flush result of the head job is out
  logic        can_load;
  logic        load_pre;

  assign can_load = !out_valid || rsp.ready;
  assign load_pre = head_job.has_pre && !phase;
  assign pop      = can_load && avail && !load_pre;

  assign rsp.valid       = out_valid;
  assign rsp.result_kind = out_kind;
  assign rsp.word_offset = out_woff;
  assign rsp.result_data = out_data;
  assign rsp.last        = out_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      phase     <= 1'b0;
    end else if (can_load) begin
      out_valid <= avail;
      if (avail) begin
        phase <= load_pre;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (can_load && avail) begin
      if (load_pre) begin
        out_kind <= RES_WRITE;
        out_woff <= OFF_BLOCK_SIZE;
        out_data <= head_job.pre_data;
        out_last <= 1'b0;
      end else begin
        out_kind <= head_job.kind;
        out_woff <= head_job.woff;
        out_data <= head_job.data;
        out_last <= 1'b1;
      end
    end
  end

endmodule

### rtl/narrow_access_word_bridge.sv
`timescale 1ns / 1ps
// Narrow access word bridge, top level. A result passes from the job queue
// into the output register and is held there while the output side stalls.
// Throughput: one item a cycle while the queue has room; a command write that
// flushes a held block word yields a flush item and then the command item,
// which the output register issues one result item per cycle when taken.
// Reset (synchronous): shadows cleared to zero, flush flag and job queue
// emptied; no clearing pass.
module narrow_access_word_bridge #(
  parameter int unsigned REG_SPACE_BYTES = 256
) (
  input  logic        clk,
  input  logic        rst,
  nawb_req_if.sink    req,
  nawb_rsp_if.source  rsp,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data
);
  import nawb_pkg::*;

  // front end to queue
  logic  push;
  job_t  push_job;
  logic  room;
  // queue to back end
  logic  pop;
  logic  avail;
  job_t  head_job;

  // Front: offset wrap, lane select/merge, shadow words and the pending
  // block flag all live here, so each item sees the state its predecessor
  // left without waiting for results to drain.
  nawb_front #(
    .REG_SPACE_BYTES(REG_SPACE_BYTES)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .req      (req),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .room     (room),
    .push     (push),
    .push_job (push_job)
  );

  // Two-entry job queue; decouples request acceptance from result stalls.
  nawb_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .push_job(push_job),
    .room    (room),
    .pop     (pop),
    .avail   (avail),
    .head_job(head_job)
  );

  // Back: issues the optional block flush item, then the main item.
  nawb_back u_back (
    .clk     (clk),
    .rst     (rst),
    .avail   (avail),
    .head_job(head_job),
    .pop     (pop),
    .rsp     (rsp)
  );

  // Only the block flush is ever a non-final item
  a_flush_form: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && !rsp.last |->
      rsp.result_kind == RES_WRITE && rsp.word_offset == OFF_BLOCK_SIZE)
    else $error("non-final item is not a block flush");

  // A taken flush is followed at once by the command word write
  a_flush_then_cmd: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.ready && !rsp.last |=>
      rsp.valid && rsp.last && rsp.result_kind == RES_WRITE &&
      rsp.word_offset == OFF_XFER_MODE)
    else $error("flush not followed by command write");

  // Read items are single and carry no offset
  a_read_form: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.result_kind == RES_READ |-> rsp.last && rsp.word_offset == 8'd0)
    else $error("malformed read item");

  // Front never pushes into a full queue
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> room)
    else $error("job pushed into full queue");

endmodule
